[hdl/assert_macros.svh]
// Assertion helpers for the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/ytps_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ytps_pkg
// Geometry, codes and helpers for the Young tableau priority store.
// ---------------------------------------------------------------------------
package ytps_pkg;

   // Table geometry
   localparam int ROWS   = 8;
   localparam int COLS   = 8;
   localparam int DEPTH  = ROWS * COLS;
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLS);
   localparam int ADDR_W = $clog2(DEPTH);

   // Item field widths
   localparam int CMD_W    = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   // Empty-cell marker
   localparam logic signed [VALUE_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT  = 2'd0,
      CMD_EXTRACT = 2'd1,
      CMD_FIND    = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIRST,
      S_READ,
      S_EVAL,
      S_RESP
   } state_type;

   // Linear memory address of cell (r, c)
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
      return ADDR_W'(int'(r) * COLS + int'(c));
   endfunction

endpackage

[hdl/young_tableau_priority_store_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// young_tableau_priority_store_core
// Start accept to rsp_strobe: insert/extract check the corner cell (S_FIRST),
// find starts in S_EVAL, the empty marker on find and unused commands go to
// S_RESP; each visited cell costs a read (S_READ) plus a compare/write (S_EVAL).
// No new item is taken until S_IDLE again; busy holds through the strobe.
// Reset (synchronous) empties the table through per-cell valid bits at once.
// ---------------------------------------------------------------------------
module young_tableau_priority_store_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [ytps_pkg::CMD_W-1:0]          req_command,
   input  logic signed [ytps_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_strobe,
   output logic signed [ytps_pkg::VALUE_W-1:0] rsp_result_value,
   output logic                                rsp_found,
   output logic [ytps_pkg::STATUS_W-1:0]       rsp_status
);
   import ytps_pkg::*;

   `include "assert_macros.svh"

   // Cell storage: two read ports, one write port, registered reads
   logic signed [VALUE_W-1:0] cell_mem_ff [DEPTH];
   logic [DEPTH-1:0]          cell_vld_ff;
   logic signed [VALUE_W-1:0] rd_a_ff, rd_b_ff;
   logic                      rd_a_vld_ff, rd_b_vld_ff;
   logic [ADDR_W-1:0]         rd_addr_a, rd_addr_b, wr_addr;
   logic                      wr_en;
   logic signed [VALUE_W-1:0] wr_data;

   // Control and item registers
   state_type                 state_ff, state_in;
   logic [CMD_W-1:0]          op_ff, op_in;
   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic signed [VALUE_W-1:0] mov_ff, mov_in;
   logic [ROW_W-1:0]          row_ff, row_in;
   logic [COL_W-1:0]          col_ff, col_in;
   logic signed [VALUE_W-1:0] res_ff, res_in;
   logic                      found_ff, found_in;
   logic [STATUS_W-1:0]       status_ff, status_in;

   // Effective read data: unwritten cells read as empty
   logic signed [VALUE_W-1:0] qa, qb, best;
   logic                      has_a, has_b, pick_a, pick_b;

   // Result fields of a find: status ok and no value
   logic                      rsp_clean;

   assign qa = rd_a_vld_ff ? rd_a_ff : INT_MAX;
   assign qb = rd_b_vld_ff ? rd_b_ff : INT_MAX;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cell_mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff     <= cell_mem_ff[rd_addr_a];
      rd_b_ff     <= cell_mem_ff[rd_addr_b];
      rd_a_vld_ff <= cell_vld_ff[rd_addr_a];
      rd_b_vld_ff <= cell_vld_ff[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_vld_ff <= '0;
      end else if (wr_en) begin
         cell_vld_ff[wr_addr] <= 1'b1;
      end
   end

   // State and item registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      val_ff    <= val_in;
      mov_ff    <= mov_in;
      row_ff    <= row_in;
      col_ff    <= col_in;
      res_ff    <= res_in;
      found_ff  <= found_in;
      status_ff <= status_in;
   end

   // Sequencer: read neighbors, compare, write one cell, move
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      val_in    = val_ff;
      mov_in    = mov_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      res_in    = res_ff;
      found_in  = found_ff;
      status_in = status_ff;
      rd_addr_a = cell_addr(row_ff, col_ff);
      rd_addr_b = cell_addr(row_ff, col_ff);
      wr_en     = 1'b0;
      wr_addr   = cell_addr(row_ff, col_ff);
      wr_data   = mov_ff;
      has_a     = 1'b0;
      has_b     = 1'b0;
      pick_a    = 1'b0;
      pick_b    = 1'b0;
      best      = mov_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in     = req_command;
               val_in    = req_value;
               res_in    = '0;
               found_in  = 1'b0;
               status_in = ST_OK;
               case (req_command)
                  CMD_INSERT: begin
                     row_in   = ROW_W'(ROWS - 1);
                     col_in   = COL_W'(COLS - 1);
                     state_in = S_FIRST;
                  end
                  CMD_EXTRACT: begin
                     row_in   = '0;
                     col_in   = '0;
                     state_in = S_FIRST;
                  end
                  CMD_FIND: begin
                     row_in   = ROW_W'(ROWS - 1);
                     col_in   = '0;
                     // the empty marker never counts as stored
                     state_in = (req_value == INT_MAX) ? S_RESP : S_EVAL;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
               rd_addr_a = cell_addr(row_in, col_in);
            end
         end

         // Corner cell check: full on insert, empty on extract
         S_FIRST: begin
            case (op_ff)
               CMD_INSERT: begin
                  if (qa != INT_MAX) begin
                     status_in = ST_FULL;
                     state_in  = S_RESP;
                  end else begin
                     mov_in   = val_ff;
                     state_in = S_READ;
                  end
               end
               CMD_EXTRACT: begin
                  if (qa == INT_MAX) begin
                     res_in    = INT_MAX;
                     status_in = ST_EMPTY;
                     state_in  = S_RESP;
                  end else begin
                     res_in   = qa;
                     mov_in   = INT_MAX;
                     state_in = S_READ;
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end

         // Issue neighbor reads; missing neighbors read the current cell
         S_READ: begin
            case (op_ff)
               CMD_INSERT: begin
                  if (row_ff != '0) begin
                     rd_addr_a = cell_addr(row_ff - 1'b1, col_ff);
                  end
                  if (col_ff != '0) begin
                     rd_addr_b = cell_addr(row_ff, col_ff - 1'b1);
                  end
               end
               CMD_EXTRACT: begin
                  if (row_ff != ROW_W'(ROWS - 1)) begin
                     rd_addr_a = cell_addr(row_ff + 1'b1, col_ff);
                  end
                  if (col_ff != COL_W'(COLS - 1)) begin
                     rd_addr_b = cell_addr(row_ff, col_ff + 1'b1);
                  end
               end
               default: begin
               end
            endcase
            state_in = S_EVAL;
         end

         // Compare and move one cell, or take one find step
         S_EVAL: begin
            case (op_ff)
               CMD_INSERT: begin
                  has_a  = (row_ff != '0);
                  has_b  = (col_ff != '0);
                  pick_a = has_a && (qa > mov_ff);
                  best   = pick_a ? qa : mov_ff;
                  pick_b = has_b && (qb > best);
                  wr_en  = 1'b1;
                  if (pick_b) begin
                     wr_data  = qb;
                     col_in   = col_ff - 1'b1;
                     state_in = S_READ;
                  end else if (pick_a) begin
                     wr_data  = qa;
                     row_in   = row_ff - 1'b1;
                     state_in = S_READ;
                  end else begin
                     wr_data  = mov_ff;
                     state_in = S_RESP;
                  end
               end
               CMD_EXTRACT: begin
                  has_a  = (row_ff != ROW_W'(ROWS - 1));
                  has_b  = (col_ff != COL_W'(COLS - 1));
                  pick_a = has_a && (qa < mov_ff);
                  best   = pick_a ? qa : mov_ff;
                  pick_b = has_b && (qb < best);
                  wr_en  = 1'b1;
                  if (pick_b) begin
                     wr_data  = qb;
                     col_in   = col_ff + 1'b1;
                     state_in = S_READ;
                  end else if (pick_a) begin
                     wr_data  = qa;
                     row_in   = row_ff + 1'b1;
                     state_in = S_READ;
                  end else begin
                     wr_data  = mov_ff;
                     state_in = S_RESP;
                  end
               end
               CMD_FIND: begin
                  // staircase: up when smaller, right when larger
                  if (val_ff == qa) begin
                     found_in = 1'b1;
                     state_in = S_RESP;
                  end else if (val_ff < qa) begin
                     if (row_ff == '0) begin
                        state_in = S_RESP;
                     end else begin
                        row_in   = row_ff - 1'b1;
                        state_in = S_READ;
                     end
                  end else begin
                     if (col_ff == COL_W'(COLS - 1)) begin
                        state_in = S_RESP;
                     end else begin
                        col_in   = col_ff + 1'b1;
                        state_in = S_READ;
                     end
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end

         S_RESP: begin
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Outputs
   assign busy             = (state_ff != S_IDLE);
   assign rsp_strobe       = (state_ff == S_RESP);
   assign rsp_result_value = res_ff;
   assign rsp_found        = found_ff;
   assign rsp_status       = status_ff;

   // Checks
   assign rsp_clean = (rsp_status == ST_OK) && (rsp_result_value == '0);

   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "busy not raised")
   `ASSERT_NEXT(a_strobe_frees, clock, reset, rsp_strobe, !busy && !rsp_strobe, "still busy")
   `ASSERT_IMPLIES(a_found_clean, clock, reset, rsp_strobe && rsp_found, rsp_clean, "dirty find")

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the Young tableau priority store. A scoreboard
// class keeps its own copy of the table and predicts the reply to every
// accepted item. The bench runs a short directed pass over the edge cases,
// then random fill, drain and mixed phases with bursty start timing.
// ---------------------------------------------------------------------------
module tb;
   import ytps_pkg::*;

   localparam int CLK_HALF     = 10;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int TAIL_CYCLES  = 2 * (ROWS + COLS) + 8;
   localparam int RAND_ITEMS   = 1650;
   localparam int PHASE_ITEMS  = 130;
   localparam logic signed [VALUE_W-1:0] INT_MIN = 32'sh8000_0000;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef enum int {
      MODE_FILL,
      MODE_DRAIN,
      MODE_MIXED
   } phase_mode_type;

   // One expected reply
   typedef struct {
      logic signed [VALUE_W-1:0] value;
      logic                      found;
      logic [STATUS_W-1:0]       status;
   } reply_type;

   // ------------------------------------------------------------------------
   // Scoreboard: shadow table plus queue of replies still owed by the block
   // ------------------------------------------------------------------------
   class tableau_scoreboard;
      logic signed [VALUE_W-1:0] cells [DEPTH];
      reply_type owed_replies [$];
      int errors;

      function new();
         foreach (cells[i]) cells[i] = INT_MAX;
         errors = 0;
      endfunction

      function logic signed [VALUE_W-1:0] cell_at(int r, int c);
         return cells[r * COLS + c];
      endfunction

      function void swap_cells(int r0, int c0, int r1, int c1);
         logic signed [VALUE_W-1:0] t;
         t = cells[r0 * COLS + c0];
         cells[r0 * COLS + c0] = cells[r1 * COLS + c1];
         cells[r1 * COLS + c1] = t;
      endfunction

      // New value sits bottom-right; move it up/left past larger neighbors
      function void sift_up_left();
         int r, c, br, bc;
         r = ROWS - 1;
         c = COLS - 1;
         forever begin
            br = r;
            bc = c;
            if (r > 0 && cell_at(r - 1, c) > cell_at(br, bc)) begin
               br = r - 1;
               bc = c;
            end
            if (c > 0 && cell_at(r, c - 1) > cell_at(br, bc)) begin
               br = r;
               bc = c - 1;
            end
            if (br == r && bc == c) break;
            swap_cells(r, c, br, bc);
            r = br;
            c = bc;
         end
      endfunction

      // Hole at top-left; pull the smaller neighbor in until order holds
      function void sift_down_right();
         int r, c, sr, sc;
         r = 0;
         c = 0;
         forever begin
            sr = r;
            sc = c;
            if (r + 1 < ROWS && cell_at(r + 1, c) < cell_at(sr, sc)) begin
               sr = r + 1;
               sc = c;
            end
            if (c + 1 < COLS && cell_at(r, c + 1) < cell_at(sr, sc)) begin
               sr = r;
               sc = c + 1;
            end
            if (sr == r && sc == c) break;
            swap_cells(r, c, sr, sc);
            r = sr;
            c = sc;
         end
      endfunction

      // Staircase walk from bottom-left; the empty marker never matches
      function logic staircase_find(logic signed [VALUE_W-1:0] v);
         int r, c;
         logic signed [VALUE_W-1:0] x;
         r = ROWS - 1;
         c = 0;
         if (v == INT_MAX) return 1'b0;
         while (r >= 0 && c < COLS) begin
            x = cell_at(r, c);
            if (v == x) return 1'b1;
            if (v < x) r--;
            else c++;
         end
         return 1'b0;
      endfunction

      // Accepted item: update the shadow table and queue the reply
      function void note_command(logic [CMD_W-1:0] cmd, logic signed [VALUE_W-1:0] v);
         reply_type rep;
         rep.value  = '0;
         rep.found  = 1'b0;
         rep.status = ST_OK;
         case (cmd)
            CMD_INSERT: begin
               if (cell_at(ROWS - 1, COLS - 1) != INT_MAX) begin
                  rep.status = ST_FULL;
               end else begin
                  cells[DEPTH - 1] = v;
                  sift_up_left();
               end
            end
            CMD_EXTRACT: begin
               if (cells[0] == INT_MAX) begin
                  rep.value  = INT_MAX;
                  rep.status = ST_EMPTY;
               end else begin
                  rep.value = cells[0];
                  cells[0]  = INT_MAX;
                  sift_down_right();
               end
            end
            CMD_FIND: rep.found = staircase_find(v);
            default: ;
         endcase
         owed_replies.push_back(rep);
      endfunction

      function void flag(string what, longint exp_v, longint act_v);
         errors++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                  $time, what, exp_v, act_v);
      endfunction

      // Strobed reply: compare with the oldest owed reply
      function void check_reply(logic signed [VALUE_W-1:0] value, logic found,
                                logic [STATUS_W-1:0] status);
         reply_type rep;
         if (owed_replies.size() == 0) begin
            flag("unexpected reply, result_value", 0, value);
            return;
         end
         rep = owed_replies.pop_front();
         if (value !== rep.value) flag("result_value", rep.value, value);
         if (found !== rep.found) flag("found", rep.found, found);
         if (status !== rep.status) flag("status", rep.status, status);
      endfunction

      function int owed_count();
         return owed_replies.size();
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // Signals and DUT
   // ------------------------------------------------------------------------
   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [CMD_W-1:0]          req_command;
   logic signed [VALUE_W-1:0] req_value;
   logic                      rsp_strobe;
   logic signed [VALUE_W-1:0] rsp_result_value;
   logic                      rsp_found;
   logic [STATUS_W-1:0]       rsp_status;

   tableau_scoreboard sb;
   int unsigned cycle_count = 0;
   logic signed [VALUE_W-1:0] recent_inserts [16];
   int recent_idx;

   young_tableau_priority_store_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_value        (req_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_result_value (rsp_result_value),
      .rsp_found        (rsp_found),
      .rsp_status       (rsp_status)
   );

   initial clock = 1'b0;
   always #(CLK_HALF) clock = ~clock;

   // Replies first, then the item taken at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) sb.check_reply(rsp_result_value, rsp_found, rsp_status);
         if (start && !busy) sb.note_command(req_command, req_value);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------------
   // Idle for the gap, raise start, hold until the item is taken
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic signed [VALUE_W-1:0] v,
                            input int gap);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start       <= 1'b1;
      req_command <= cmd;
      req_value   <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (cmd == CMD_INSERT) begin
         recent_inserts[recent_idx] = v;
         recent_idx = (recent_idx + 1) % 16;
      end
   endtask

   // Mix of clustered small values, extremes and full-range words
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $signed($urandom_range(0, 16)) - 8;
         4: begin
            case ($urandom_range(0, 5))
               0: return INT_MIN;
               1: return INT_MIN + 1;
               2: return INT_MAX - 1;
               3: return 0;
               4: return -1;
               default: return INT_MAX;
            endcase
         end
         default: return $signed($urandom);
      endcase
   endfunction

   function automatic logic [CMD_W-1:0] pick_command(phase_mode_type mode);
      int roll;
      int ins_w, ext_w;
      roll = $urandom_range(0, 99);
      case (mode)
         MODE_FILL:  begin ins_w = 75; ext_w = 10; end
         MODE_DRAIN: begin ins_w = 15; ext_w = 70; end
         default:    begin ins_w = 40; ext_w = 30; end
      endcase
      if (roll < ins_w) return CMD_INSERT;
      if (roll < ins_w + ext_w) return CMD_EXTRACT;
      if (roll < 98) return CMD_FIND;
      return CMD_UNUSED;
   endfunction

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      logic [CMD_W-1:0]          cmd;
      logic signed [VALUE_W-1:0] v;
      phase_mode_type            mode;
      int                        gap, burst_left, wait_cycles;
      bit                        no_idle;

      sb          = new();
      recent_idx  = 0;
      foreach (recent_inserts[i]) recent_inserts[i] = '0;
      reset       = 1'b1;
      start       = 1'b0;
      req_command = CMD_INSERT;
      req_value   = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty table, empty marker, unused code, extremes, duplicates
      send_item(CMD_EXTRACT, $signed($urandom), 1);
      send_item(CMD_FIND, 0, $urandom_range(0, 2));
      send_item(CMD_INSERT, INT_MAX, $urandom_range(0, 2));
      send_item(CMD_FIND, INT_MAX, $urandom_range(0, 2));
      send_item(CMD_UNUSED, $signed($urandom), $urandom_range(0, 2));
      send_item(CMD_INSERT, 0, $urandom_range(0, 2));
      send_item(CMD_INSERT, INT_MIN, $urandom_range(0, 2));
      send_item(CMD_INSERT, INT_MAX - 1, $urandom_range(0, 2));
      send_item(CMD_INSERT, -1, $urandom_range(0, 2));
      send_item(CMD_INSERT, 5, $urandom_range(0, 2));
      send_item(CMD_INSERT, 5, $urandom_range(0, 2));
      send_item(CMD_FIND, INT_MIN, $urandom_range(0, 2));
      send_item(CMD_FIND, INT_MAX - 1, $urandom_range(0, 2));
      send_item(CMD_FIND, 7, $urandom_range(0, 2));
      send_item(CMD_FIND, INT_MAX, $urandom_range(0, 2));
      send_item(CMD_EXTRACT, $signed($urandom), $urandom_range(0, 2));
      send_item(CMD_EXTRACT, $signed($urandom), $urandom_range(0, 2));
      send_item(CMD_INSERT, INT_MAX, $urandom_range(0, 2));
      send_item(CMD_UNUSED, $signed($urandom), $urandom_range(0, 2));
      repeat (5) send_item(CMD_EXTRACT, $signed($urandom), $urandom_range(0, 2));

      // Random phases: fill-heavy, drain-heavy and mixed traffic
      burst_left = 0;
      for (int n = 0; n < RAND_ITEMS; n++) begin
         mode    = phase_mode_type'((n / PHASE_ITEMS) % 3);
         no_idle = ((n / PHASE_ITEMS) % 4) == 3;
         cmd     = pick_command(mode);
         if (cmd == CMD_FIND && $urandom_range(0, 9) < 6)
            v = recent_inserts[$urandom_range(0, 15)];
         else
            v = pick_value();
         if (no_idle) begin
            gap = 0;
         end else if (burst_left == 0) begin
            gap        = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 12);
         end else begin
            gap = 0;
            burst_left--;
         end
         send_item(cmd, v, gap);
      end
      @(negedge clock);
      start <= 1'b0;

      // Drain outstanding replies, then watch for strays
      while (sb.owed_count() != 0) @(posedge clock);
      wait_cycles = TAIL_CYCLES;
      repeat (wait_cycles) @(posedge clock);

      if (sb.errors == 0 && sb.owed_count() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
